// ----- rtl/core/utf8cs_pkg.sv -----
// ----------------------------------------------------------------------------
// utf8cs_pkg
// Shared types and the charset mapping table for the UTF-8 transcoder.
// ----------------------------------------------------------------------------
package utf8cs_pkg;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_BREAK = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  char_code;
    logic [15:0] line_index;
    logic [7:0]  column;
    logic        last;
  } res_t;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int CNT_W      = 3;

  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Code point to 8-bit charset byte.
  function automatic logic [7:0] map_code(input logic [20:0] cp);
    logic [7:0] ch;
    if (cp < 21'h80) begin
      ch = cp[7:0];
    end else begin
      case (cp)
        21'h0000FC: ch = 8'hFC;
        21'h0000DC: ch = 8'hDC;
        21'h0000F6: ch = 8'hF6;
        21'h0000D6: ch = 8'hD6;
        21'h0000E7: ch = 8'hE7;
        21'h0000C7: ch = 8'hC7;
        21'h00011F: ch = 8'hF0;
        21'h00011E: ch = 8'hD0;
        21'h00015F: ch = 8'hFE;
        21'h00015E: ch = 8'hDE;
        21'h000131: ch = 8'hFD;
        21'h000130: ch = 8'hDD;
        21'h0000D7: ch = 8'hF7;
        21'h0000F7: ch = 8'hF8;
        default:    ch = CH_QMARK;
      endcase
    end
    return ch;
  endfunction

endpackage

// ----- rtl/core/utf8cs_decoder.sv -----
// ----------------------------------------------------------------------------
// utf8cs_decoder
// Sequence decoder state, line/column counters and result formation.
// ----------------------------------------------------------------------------
module utf8cs_decoder
  import utf8cs_pkg::*;
#(
  parameter int CHUNK_CHARS = 255
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data_byte,
  output res_t       res0,
  output res_t       res1,
  output logic [1:0] res_count
);

  logic [1:0]  bytes_remaining, bytes_remaining_next;
  logic [20:0] code_accum, code_accum_next;
  logic        accum_stopped, accum_stopped_next;
  logic [15:0] line_count, line_count_next;
  logic [7:0]  column_count, column_count_next;

  logic [20:0] cp;
  logic        do_deliver;
  logic        add_finish;
  logic [1:0]  rem_dec;
  logic [20:0] accum_shift;
  logic [7:0]  ch;
  logic [8:0]  col_inc;
  logic [7:0]  col_adv;

  assign rem_dec     = bytes_remaining - 2'd1;
  assign accum_shift = {code_accum[14:0], data_byte[5:0]};
  assign col_inc     = {1'b0, column_count} + 9'd1;
  assign col_adv     = (int'(col_inc) >= CHUNK_CHARS) ? 8'd0 : col_inc[7:0];

  always_comb begin
    bytes_remaining_next = bytes_remaining;
    code_accum_next      = code_accum;
    accum_stopped_next   = accum_stopped;
    line_count_next      = line_count;
    column_count_next    = column_count;
    cp                   = '0;
    do_deliver           = 1'b0;
    add_finish           = 1'b0;
    res0                 = '0;
    res1                 = '0;
    res_count            = 2'd0;

    if (bytes_remaining == 2'd0) begin
      if (data_byte < 8'h80) begin
        cp         = {13'd0, data_byte};
        do_deliver = 1'b1;
      end else if ((data_byte & 8'hE0) == 8'hC0) begin
        code_accum_next      = {16'd0, data_byte[4:0]};
        bytes_remaining_next = 2'd1;
        accum_stopped_next   = 1'b0;
      end else if ((data_byte & 8'hF0) == 8'hE0) begin
        code_accum_next      = {17'd0, data_byte[3:0]};
        bytes_remaining_next = 2'd2;
        accum_stopped_next   = 1'b0;
      end else if ((data_byte & 8'hF8) == 8'hF0) begin
        code_accum_next      = {18'd0, data_byte[2:0]};
        bytes_remaining_next = 2'd3;
        accum_stopped_next   = 1'b0;
      end else begin
        cp         = {13'd0, CH_QMARK};
        do_deliver = 1'b1;
      end
    end else if (data_byte == 8'd0) begin
      // NUL inside a sequence: flush the partial character, then end
      cp                   = code_accum;
      do_deliver           = 1'b1;
      add_finish           = (code_accum != '0);
      bytes_remaining_next = 2'd0;
      code_accum_next      = '0;
      accum_stopped_next   = 1'b0;
    end else begin
      if (!accum_stopped && (data_byte[7:6] == 2'b10)) begin
        code_accum_next = accum_shift;
      end else begin
        accum_stopped_next = 1'b1;
      end
      bytes_remaining_next = rem_dec;
      if (rem_dec == 2'd0) begin
        cp                 = code_accum_next;
        do_deliver         = 1'b1;
        code_accum_next    = '0;
        accum_stopped_next = 1'b0;
      end
    end

    ch = map_code(cp);

    if (do_deliver) begin
      res_count       = 2'd1;
      res0.line_index = line_count;
      res0.column     = column_count;
      if (cp == '0) begin
        res0.kind            = KIND_END;
        line_count_next      = '0;
        column_count_next    = '0;
        bytes_remaining_next = 2'd0;
        code_accum_next      = '0;
        accum_stopped_next   = 1'b0;
      end else if (ch == CH_LF || ch == CH_CR) begin
        res0.kind         = KIND_BREAK;
        line_count_next   = line_count + 16'd1;
        column_count_next = '0;
      end else begin
        res0.kind         = KIND_CHAR;
        res0.char_code    = ch;
        column_count_next = col_adv;
      end
      if (add_finish) begin
        res_count         = 2'd2;
        res1.kind         = KIND_END;
        res1.line_index   = line_count_next;
        res1.column       = column_count_next;
        res1.last         = 1'b1;
        line_count_next   = '0;
        column_count_next = '0;
      end else begin
        res0.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= '0;
      code_accum      <= '0;
      accum_stopped   <= 1'b0;
      line_count      <= '0;
      column_count    <= '0;
    end else if (step) begin
      bytes_remaining <= bytes_remaining_next;
      code_accum      <= code_accum_next;
      accum_stopped   <= accum_stopped_next;
      line_count      <= line_count_next;
      column_count    <= column_count_next;
    end
  end

endmodule

// ----- rtl/core/utf8cs_fifo.sv -----
// ----------------------------------------------------------------------------
// utf8cs_fifo
// Four-entry result queue; takes up to two results a cycle, gives one.
// ----------------------------------------------------------------------------
module utf8cs_fifo
  import utf8cs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       push_count,
  input  res_t             push0,
  input  res_t             push1,
  input  logic             pop,
  output res_t             head,
  output logic             not_empty,
  output logic [CNT_W-1:0] count
);

  res_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W-1:0] wr_ptr1;
  logic             do_pop;

  assign wr_ptr1   = wr_ptr + PTR_W'(1);
  assign not_empty = (count != '0);
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      mem[wr_ptr1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_count);
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push_count) - CNT_W'(do_pop);
    end
  end

endmodule

// ----- rtl/core/utf8_to_byte_charset_transcoder.sv -----
// ----------------------------------------------------------------------------
// utf8_to_byte_charset_transcoder
// UTF-8 byte stream to 8-bit charset characters with line and column.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                         | tuser    | tlast
//  --------+-----+-------------------------------+----------+-----------------
//  s_      | in  | data_byte[7:0]                | -        | -
//  m_      | out | char_code, line_index, column | kind     | last of byte
//
//  One byte per cycle sustained while the queue has room. An accepted byte
//  sits in the input register until the queue can take two results, is
//  decoded in a single pass and its zero, one or two results go into a
//  four-entry queue that feeds the master side, through which they reach m_.
//  s_tready drops only when the queue lacks room for two results; a stall
//  on m_ therefore backs up into s_ once the queue fills.
//  rst is synchronous: it clears decoder state, counters and the queue.
//
module utf8_to_byte_charset_transcoder
  import utf8cs_pkg::*;
#(
  parameter int CHUNK_CHARS = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] char_code, [23:8] line_index, [31:24] column
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast
);

  // Input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       process;

  // Decoder results
  res_t       res0, res1;
  logic [1:0] res_count;

  // Result queue
  res_t             head;
  logic             not_empty;
  logic [CNT_W-1:0] fifo_count;

  // Room for the worst case of two results, judged before this cycle's pop.
  assign process  = in_valid && (fifo_count <= CNT_W'(FIFO_DEPTH - 2));
  assign s_tready = !in_valid || process;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (process) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  utf8cs_decoder #(
    .CHUNK_CHARS(CHUNK_CHARS)
  ) u_decoder (
    .clk       (clk),
    .rst       (rst),
    .step      (process),
    .data_byte (in_byte),
    .res0      (res0),
    .res1      (res1),
    .res_count (res_count)
  );

  utf8cs_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_count (process ? res_count : 2'd0),
    .push0      (res0),
    .push1      (res1),
    .pop        (m_tready),
    .head       (head),
    .not_empty  (not_empty),
    .count      (fifo_count)
  );

  assign m_tvalid = not_empty;
  assign m_tdata  = {head.column, head.line_index, head.char_code};
  assign m_tuser  = head.kind;
  assign m_tlast  = head.last;

  // Queue never overfills.
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  // Back-pressure on s_ only ever comes from a held input byte.
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid)
    else $error("s_tready low with empty input register");

  // The first of a pair is never the end-of-string result.
  a_pair_first: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tuser != KIND_END))
    else $error("end of string not last of its byte");

  // The second of a pair is queued alongside and follows at once.
  a_pair_second: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tuser == KIND_END && m_tlast))
    else $error("pair not closed by end of string");

endmodule
